// File: rtl/core/bbd_pkg.sv
// Shared types and constants for the Bayer demosaic block.
`timescale 1ns / 1ps
`default_nettype none
package bbd_pkg;

  localparam int PIX_W      = 16;
  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = 12;   // column index into one line bank
  localparam int WID_W      = 13;   // image_width register
  localparam int HGT_W      = 16;   // image_height register
  localparam int IN_ROW_W   = 17;   // arriving row may run past the last row while draining
  localparam int LAG_W      = 14;   // holds up to MAX_WIDTH + 1

  // configuration register indexes
  localparam logic [1:0] CFG_BAYER_PATTERN = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd2;

  // mosaic layouts
  localparam logic [1:0] PAT_RGGB = 2'd0;
  localparam logic [1:0] PAT_BGGR = 2'd1;
  localparam logic [1:0] PAT_GRBG = 2'd2;
  localparam logic [1:0] PAT_GBRG = 2'd3;

  // colour sampled at an output site
  localparam logic [1:0] SITE_RED     = 2'd0;
  localparam logic [1:0] SITE_BLUE    = 2'd1;
  localparam logic [1:0] SITE_G_RROW  = 2'd2;  // green, red neighbors left/right
  localparam logic [1:0] SITE_G_BROW  = 2'd3;  // green, blue neighbors left/right

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_value;
    logic [PIX_W-1:0] green_value;
    logic [PIX_W-1:0] blue_value;
    logic             frame_end;
  } out_item_t;

  // edge and colour info for one output site
  typedef struct packed {
    logic       x_zero;
    logic       x_end;
    logic       y_zero;
    logic       y_end;
    logic       last;
    logic [1:0] sel;
  } site_t;

endpackage
`default_nettype wire

// File: rtl/core/bilinear_bayer_demosaic_top.sv
// Streaming bilinear Bayer demosaic: line store, 3x3 window and RGB averaging.
//
//   channel | direction | handshake        | payload
//   in_     | input     | valid / stall    | in_item_t  (operation, pixel_value)
//   out_    | output    | valid / stall    | out_item_t (red, green, blue, frame_end)
//   cfg_    | input     | write enable     | index 0..2, 16-bit data
//
// One item per clock sustained unless a stalled output holds back an emitting item. An item passes
// through the counter/address stage, then the RAM read and window/average stage, then sits in the
// output register; the line store RAMs are read once per kept item, written only for in-frame items.
// Reset is synchronous; the line store is not cleared and needs no startup pass.
// A stalled output register holds the input only while the window stage holds an emitting item.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_bayer_demosaic_top
  import bbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  // configuration
  logic [1:0]       pattern_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= PAT_RGGB;
      width_r   <= WID_W'(MAX_WIDTH);
      height_r  <= HGT_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BAYER_PATTERN: pattern_r <= cfg_wdata[1:0];
        CFG_IMAGE_WIDTH:   width_r   <= cfg_wdata[WID_W-1:0];
        CFG_IMAGE_HEIGHT:  height_r  <= cfg_wdata[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;

  always_comb begin
    if (width_r < WID_W'(2)) begin
      w_eff = WID_W'(2);
    end else if (width_r > WID_W'(MAX_WIDTH)) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r < HGT_W'(2)) ? HGT_W'(2) : height_r;
  end

  // handshake / pipeline control
  logic out_free, s1_move, fire;
  logic s1_valid_r, s1_valid_nxt;
  logic s1_emit_r, s1_acc_r, s1_bank_r;
  logic [PIX_W-1:0] s1_pix_r;
  site_t s1_site_r;

  assign out_free = !out_valid || !out_stall;
  assign s1_move  = s1_valid_r && (!s1_emit_r || out_free);
  assign in_stall = s1_valid_r && !s1_move;
  assign fire     = in_valid && !in_stall;

  // stage 0: counters, site decode, RAM addressing
  logic [COL_W-1:0]    in_col_r, in_col_nxt;
  logic [IN_ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]    out_col_r, out_col_nxt;
  logic [HGT_W-1:0]    out_row_r, out_row_nxt;
  logic [LAG_W-1:0]    lag_r, lag_nxt;

  logic  in_active, ignore, emit, in_col_end, rx, ry;
  site_t site;

  always_comb begin
    in_active  = in_row_r < IN_ROW_W'(h_eff);
    ignore     = in_active && (in_item.operation == OP_FLUSH);
    in_col_end = ({1'b0, in_col_r} + WID_W'(1)) >= w_eff;
    emit       = lag_r >= ({1'b0, w_eff} + LAG_W'(1));

    rx = (pattern_r == PAT_BGGR) || (pattern_r == PAT_GRBG);
    ry = (pattern_r == PAT_BGGR) || (pattern_r == PAT_GBRG);

    site.x_zero = (out_col_r == '0);
    site.x_end  = ({1'b0, out_col_r} + WID_W'(1)) >= w_eff;
    site.y_zero = (out_row_r == '0);
    site.y_end  = ({1'b0, out_row_r} + 17'd1) >= {1'b0, h_eff};
    site.last   = site.x_end && site.y_end;
    if (out_col_r[0] == rx && out_row_r[0] == ry) begin
      site.sel = SITE_RED;
    end else if (out_col_r[0] != rx && out_row_r[0] != ry) begin
      site.sel = SITE_BLUE;
    end else if (out_row_r[0] == ry) begin
      site.sel = SITE_G_RROW;
    end else begin
      site.sel = SITE_G_BROW;
    end

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    lag_nxt     = lag_r;
    if (fire && !ignore) begin
      if (in_col_end) begin
        in_col_nxt = '0;
        if (in_row_r != '1) begin
          in_row_nxt = in_row_r + IN_ROW_W'(1);
        end
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end
      if (!emit) begin
        lag_nxt = lag_r + LAG_W'(1);
      end
      if (emit) begin
        if (site.last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          lag_nxt     = '0;
        end else if (site.x_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HGT_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      lag_r     <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      lag_r     <= lag_nxt;
    end
  end

  // line store: one bank per row parity
  logic             rd_en, wr_en0, wr_en1;
  logic [PIX_W-1:0] rdata0, rdata1;

  assign rd_en  = fire && !ignore;
  assign wr_en0 = rd_en && in_active && !in_row_r[0];
  assign wr_en1 = rd_en && in_active && in_row_r[0];

  bbd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank0 (
    .clk   (clk),
    .we    (wr_en0),
    .waddr (in_col_r),
    .wdata (in_item.pixel_value),
    .re    (rd_en),
    .raddr (in_col_r),
    .rdata (rdata0)
  );

  bbd_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_bank1 (
    .clk   (clk),
    .we    (wr_en1),
    .waddr (in_col_r),
    .wdata (in_item.pixel_value),
    .re    (rd_en),
    .raddr (in_col_r),
    .rdata (rdata1)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (fire) begin
      s1_valid_nxt = !ignore;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (fire) begin
      s1_emit_r <= emit;
      s1_acc_r  <= in_active;
      s1_bank_r <= in_row_r[0];
      s1_pix_r  <= in_item.pixel_value;
      s1_site_r <= site;
    end
  end

  // stage 1: window shift and averaging
  logic [PIX_W-1:0] win_r [3][3];
  logic [PIX_W-1:0] win_nxt [3][3];
  logic [PIX_W-1:0] top, mid, bot;
  logic [PIX_W-1:0] cl [3];
  logic [PIX_W-1:0] cc [3];
  logic [PIX_W-1:0] cr [3];
  logic [PIX_W+1:0] cross_sum, diag_sum;
  logic [PIX_W:0]   horz_sum, vert_sum;
  logic [PIX_W-1:0] center, cross_avg, diag_avg, horz_avg, vert_avg;
  out_item_t        pix_out;

  always_comb begin
    // top is two rows back, mid the previous row
    top = s1_bank_r ? rdata1 : rdata0;
    mid = s1_bank_r ? rdata0 : rdata1;
    bot = s1_acc_r ? s1_pix_r : mid;

    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = top;
    win_nxt[1][2] = mid;
    win_nxt[2][2] = bot;

    // last column: new window already holds the next row's first column
    for (int r = 0; r < 3; r++) begin
      if (s1_site_r.x_end) begin
        cl[r] = win_r[r][1];
        cc[r] = win_r[r][2];
        cr[r] = win_r[r][2];
      end else begin
        cc[r] = win_nxt[r][1];
        cr[r] = win_nxt[r][2];
        cl[r] = s1_site_r.x_zero ? win_nxt[r][1] : win_nxt[r][0];
      end
    end
    if (s1_site_r.y_zero) begin
      cl[0] = cl[1];
      cc[0] = cc[1];
      cr[0] = cr[1];
    end
    if (s1_site_r.y_end) begin
      cl[2] = cl[1];
      cc[2] = cc[1];
      cr[2] = cr[1];
    end

    center    = cc[1];
    cross_sum = (PIX_W+2)'(cl[1]) + (PIX_W+2)'(cr[1]) + (PIX_W+2)'(cc[0])
              + (PIX_W+2)'(cc[2]);
    diag_sum  = (PIX_W+2)'(cl[0]) + (PIX_W+2)'(cr[0]) + (PIX_W+2)'(cl[2])
              + (PIX_W+2)'(cr[2]);
    horz_sum  = (PIX_W+1)'(cl[1]) + (PIX_W+1)'(cr[1]);
    vert_sum  = (PIX_W+1)'(cc[0]) + (PIX_W+1)'(cc[2]);
    cross_avg = cross_sum[PIX_W+1:2];
    diag_avg  = diag_sum[PIX_W+1:2];
    horz_avg  = horz_sum[PIX_W:1];
    vert_avg  = vert_sum[PIX_W:1];

    pix_out.frame_end = s1_site_r.last;
    unique case (s1_site_r.sel)
      SITE_RED: begin
        pix_out.red_value   = center;
        pix_out.green_value = cross_avg;
        pix_out.blue_value  = diag_avg;
      end
      SITE_BLUE: begin
        pix_out.red_value   = diag_avg;
        pix_out.green_value = cross_avg;
        pix_out.blue_value  = center;
      end
      SITE_G_RROW: begin
        pix_out.red_value   = horz_avg;
        pix_out.green_value = center;
        pix_out.blue_value  = vert_avg;
      end
      default: begin
        pix_out.red_value   = vert_avg;
        pix_out.green_value = center;
        pix_out.blue_value  = horz_avg;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (s1_move) begin
      win_r <= win_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_emit_r) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (s1_move && s1_emit_r) begin
      out_item <= pix_out;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/bbd_ram.sv
// Generic single-clock RAM, one write port, one registered read port (read-first).
`timescale 1ns / 1ps
`default_nettype none
module bbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: tb/bilinear_bayer_demosaic_top_test.sv
// Self-checking testbench for the bilinear Bayer demosaic: stream driver, RGB predictor, monitor.
`timescale 1ns / 1ps
module bilinear_bayer_demosaic_top_test;
  import bbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned TARGET_ITEMS = 2000;

  localparam int STALL_NONE     = 0;
  localparam int STALL_RANDOM   = 1;
  localparam int STALL_PERIODIC = 2;
  localparam int STALL_RUNS     = 3;

  typedef struct {
    in_item_t item;
    bit       pause;
  } raw_entry_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  bilinear_bayer_demosaic_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [15:0] line_mem [0:1][0:MAX_WIDTH-1];
  logic [15:0] win [0:2][0:2];
  int unsigned in_col, in_row, out_col, out_row;
  logic [1:0]  cur_pattern;
  logic [12:0] cur_width;
  logic [15:0] cur_height;

  out_item_t   rgb_expected [$];
  raw_entry_t  raw_queue [$];

  // bookkeeping
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned queued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned counted_items = 0;
  int unsigned pixels_checked = 0;
  int unsigned frames_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned min_w = MAX_WIDTH, max_w = 0, min_h = 65535, max_h = 0;
  logic [3:0]  layouts_seen = '0;

  // driver / receiver state
  bit          in_taken = 1'b0;
  bit          hold_for_drain = 1'b0;
  bit          sender_gaps = 1'b0;
  bit          add_noise = 1'b1;
  bit          go;
  raw_entry_t  nxt;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_mode = STALL_NONE;
  int          stall_tick = 0;
  int          stall_run = 0;
  bit          stall_on = 1'b0;

  logic [15:0] corner_samples [0:11] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                                         16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                                         16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555};

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    err_cnt++;
    if (err_cnt <= 30)
      $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  task automatic reset_model();
    int b, c;
    for (b = 0; b < 2; b++)
      for (c = 0; c < MAX_WIDTH; c++) line_mem[b][c] = '0;
    for (b = 0; b < 3; b++)
      for (c = 0; c < 3; c++) win[b][c] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    cur_pattern = PAT_RGGB; cur_width = 13'd4096; cur_height = 16'd4096;
  endtask

  task automatic apply_cfg(input logic [1:0] idx, input logic [15:0] val);
    if (idx == CFG_BAYER_PATTERN) cur_pattern = val[1:0];
    else if (idx == CFG_IMAGE_WIDTH) cur_width = val[12:0];
    else if (idx == CFG_IMAGE_HEIGHT) cur_height = val;
  endtask

  // One accepted item: shift the window, update the line banks, maybe emit a pixel.
  task automatic demosaic_step(input in_item_t it);
    int unsigned w, h, col, bank, x, y, rx, ry, r, k;
    int unsigned red, green, blue, cross_avg, diag_avg, horz_avg, vert_avg;
    int unsigned cl [0:2], cc [0:2], cr [0:2];
    logic [15:0] top, mid, bot;
    logic [15:0] pre [0:2][0:2];
    longint unsigned arrive, due;
    bit accept, last;
    out_item_t px;
    w = cur_width;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = cur_height;
    if (h < 2) h = 2;
    if (in_row < h) begin
      if (it.operation == OP_FLUSH) return;
      accept = 1'b1;
    end else begin
      accept = 1'b0;
    end

    col = (in_col >= MAX_WIDTH) ? MAX_WIDTH - 1 : in_col;
    bank = in_row & 1;
    top = line_mem[bank][col];
    mid = line_mem[bank ^ 1][col];
    bot = accept ? it.pixel_value : mid;
    for (r = 0; r < 3; r++)
      for (k = 0; k < 3; k++) pre[r][k] = win[r][k];
    for (r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = bot;
    if (accept) line_mem[bank][col] = it.pixel_value;

    arrive = longint'(in_row) * w + in_col;
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row < 'h1FFFF) in_row++;
    end else begin
      in_col++;
    end

    due = longint'(out_row) * w + out_col + w + 1;
    if (arrive < due) return;

    x = out_col;
    y = out_row;
    rx = (cur_pattern == PAT_BGGR || cur_pattern == PAT_GRBG) ? 1 : 0;
    ry = (cur_pattern == PAT_BGGR || cur_pattern == PAT_GBRG) ? 1 : 0;
    last = (y + 1 >= h) && (x + 1 >= w);

    // right edge uses the window as it stood before this shift
    for (r = 0; r < 3; r++) begin
      if (x + 1 >= w) begin
        cl[r] = pre[r][1]; cc[r] = pre[r][2]; cr[r] = pre[r][2];
      end else begin
        cc[r] = win[r][1]; cr[r] = win[r][2];
        cl[r] = (x == 0) ? cc[r] : win[r][0];
      end
    end
    if (y == 0) begin
      cl[0] = cl[1]; cc[0] = cc[1]; cr[0] = cr[1];
    end
    if (y + 1 >= h) begin
      cl[2] = cl[1]; cc[2] = cc[1]; cr[2] = cr[1];
    end

    cross_avg = (cl[1] + cr[1] + cc[0] + cc[2]) >> 2;
    diag_avg  = (cl[0] + cr[0] + cl[2] + cr[2]) >> 2;
    horz_avg  = (cl[1] + cr[1]) >> 1;
    vert_avg  = (cc[0] + cc[2]) >> 1;

    if ((x & 1) == rx && (y & 1) == ry) begin
      red = cc[1]; green = cross_avg; blue = diag_avg;
    end else if ((x & 1) != rx && (y & 1) != ry) begin
      blue = cc[1]; green = cross_avg; red = diag_avg;
    end else if ((y & 1) == ry) begin
      green = cc[1]; red = horz_avg; blue = vert_avg;
    end else begin
      green = cc[1]; blue = horz_avg; red = vert_avg;
    end

    px.red_value   = red[15:0];
    px.green_value = green[15:0];
    px.blue_value  = blue[15:0];
    px.frame_end   = last;
    rgb_expected.push_back(px);

    if (last) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else if (x + 1 >= w) begin
      out_col = 0;
      out_row++;
    end else begin
      out_col++;
    end
  endtask

  task automatic check_rgb(input out_item_t got);
    out_item_t want;
    if (rgb_expected.size() == 0) begin
      report_mismatch("pixel with none expected", got, 0);
      return;
    end
    want = rgb_expected.pop_front();
    pixels_checked++;
    if (got.frame_end === 1'b1) frames_seen++;
    if (got.red_value !== want.red_value)
      report_mismatch("red_value", got.red_value, want.red_value);
    if (got.green_value !== want.green_value)
      report_mismatch("green_value", got.green_value, want.green_value);
    if (got.blue_value !== want.blue_value)
      report_mismatch("blue_value", got.blue_value, want.blue_value);
    if (got.frame_end !== want.frame_end)
      report_mismatch("frame_end", got.frame_end, want.frame_end);
  endtask

  // monitor: config writes, result transfers, input transfers
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d pixels outstanding", rgb_expected.size());
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n) begin
      if (cfg_we) apply_cfg(cfg_index, cfg_wdata);
      if (out_valid && !out_stall) check_rgb(out_item);
      if (in_valid && !in_stall) begin
        demosaic_step(in_item);
        in_taken = 1'b1;
        taken_cnt++;
      end
    end
  end

  // sender: bursts with random gaps, optional hold until all results are back
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      go = 1'b0;
      if (hold_for_drain) begin
        if (rgb_expected.size() == 0) hold_for_drain = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (raw_queue.size() > 0) begin
        nxt = raw_queue.pop_front();
        if (nxt.pause) begin
          hold_for_drain = 1'b1;
        end else begin
          go = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = sender_gaps ? $urandom_range(0, 6) : 0;
          end
        end
      end
      in_valid <= go;
      if (go) in_item <= nxt.item;
    end
  end

  // receiver stall patterns
  always @(negedge clk) begin
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
      STALL_PERIODIC: begin
        stall_tick = (stall_tick + 1) % 11;
        out_stall <= (stall_tick < 4);
      end
      default: begin
        if (stall_run == 0) begin
          stall_on = !stall_on;
          stall_run = stall_on ? $urandom_range(1, 40) : $urandom_range(1, 12);
        end
        stall_run--;
        out_stall <= stall_on;
      end
    endcase
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
  endtask

  task automatic push_raw(input logic op, input logic [15:0] val, input bit counted);
    raw_entry_t e;
    e.item.operation = op;
    e.item.pixel_value = val;
    e.pause = 1'b0;
    raw_queue.push_back(e);
    queued_cnt++;
    if (counted) counted_items++;
  endtask

  task automatic push_pause();
    raw_entry_t e;
    e.item = '0;
    e.pause = 1'b1;
    raw_queue.push_back(e);
  endtask

  function automatic logic [15:0] pick_sample();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Drain ticks mix flush items and pixel items that arrive after the last raw pixel.
  task automatic queue_drain(input int unsigned w);
    int unsigned t;
    for (t = 0; t <= w; t++)
      push_raw($urandom_range(0, 1) ? OP_FLUSH : OP_PIXEL, 16'($urandom_range(0, 65535)),
               1'b1);
  endtask

  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit with_pause);
    int unsigned r, c, n, pause_at;
    pause_at = with_pause ? $urandom_range(w + 1, w * h - 1) : w * h;
    n = 0;
    for (r = 0; r < h; r++) begin
      for (c = 0; c < w; c++) begin
        // flush while raw pixels are still due: dropped by the block
        if (add_noise && $urandom_range(0, 19) == 0)
          push_raw(OP_FLUSH, 16'($urandom_range(0, 65535)), 1'b0);
        if (n == pause_at) push_pause();
        push_raw(OP_PIXEL, pick_sample(), 1'b1);
        n++;
      end
    end
    queue_drain(w);
    if ($urandom_range(0, 3) == 0) push_raw(OP_FLUSH, 16'($urandom_range(0, 65535)), 1'b0);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (taken_cnt != queued_cnt || rgb_expected.size() != 0 || hold_for_drain)
      @(negedge clk);
  endtask

  task automatic setup_phase(input logic [15:0] pat, input logic [15:0] wid,
                             input logic [15:0] hgt);
    int unsigned w, h;
    repeat (8) @(negedge clk);  // trailing ignored items may still be in flight
    write_reg(CFG_BAYER_PATTERN, pat);
    write_reg(CFG_IMAGE_WIDTH, wid);
    write_reg(CFG_IMAGE_HEIGHT, hgt);
    w = wid[12:0];
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = hgt;
    if (h < 2) h = 2;
    if (w < min_w) min_w = w;
    if (w > max_w) max_w = w;
    if (h < min_h) min_h = h;
    if (h > max_h) max_h = h;
    layouts_seen[pat[1:0]] = 1'b1;
  endtask

  task automatic run_phase(input logic [15:0] pat, input logic [15:0] wid,
                           input logic [15:0] hgt, input int unsigned frames,
                           input bit with_pause);
    int unsigned w, h, f;
    setup_phase(pat, wid, hgt);
    w = wid[12:0];
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (hgt < 2) ? 2 : hgt;
    for (f = 0; f < frames; f++)
      queue_frame(w, h, with_pause && f == 0);
    wait_idle();
  endtask

  initial begin
    int unsigned i, phase_no;
    logic [15:0] wsel, hsel;
    reset_model();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: 4x3 RGGB frame of corner values, an ignored flush, a mixed drain
    setup_phase(PAT_RGGB, 16'd4, 16'd3);
    for (i = 0; i < 12; i++) begin
      if (i == 3) push_raw(OP_FLUSH, 16'hFFFF, 1'b0);
      push_raw(OP_PIXEL, corner_samples[i], 1'b1);
    end
    push_raw(OP_FLUSH, 16'h0000, 1'b1);
    push_raw(OP_PIXEL, 16'hFFFF, 1'b1);
    push_raw(OP_FLUSH, 16'hFFFF, 1'b1);
    push_raw(OP_PIXEL, 16'h1234, 1'b1);
    push_raw(OP_FLUSH, 16'h0000, 1'b1);
    push_raw(OP_FLUSH, 16'h0000, 1'b0);
    wait_idle();

    // random phases, small frames, all layouts, clamped sizes now and then
    phase_no = 0;
    while (counted_items < TARGET_ITEMS) begin
      sender_gaps = 1'($urandom_range(0, 1));
      stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
      case ($urandom_range(0, 19))
        0: wsel = 16'd0;
        1: wsel = 16'd1;
        2: wsel = 16'($urandom_range(17, 64));
        default: wsel = 16'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 9))
        0: hsel = 16'd0;
        1: hsel = 16'd1;
        default: hsel = 16'($urandom_range(2, 10));
      endcase
      run_phase(16'($urandom_range(0, 65535)), wsel, hsel,
                $urandom_range(1, 3), phase_no == 0 || $urandom_range(0, 2) == 0);
      phase_no++;
    end

    // tall frame at the narrowest width
    sender_gaps = 1'b0;
    stall_mode = STALL_PERIODIC;
    add_noise = 1'b0;
    run_phase({14'h0000, PAT_BGGR}, 16'd2, 16'd120, 1, 1'b1);

    repeat (20) @(negedge clk);
    $display("Ran %0d frames (%0d RGB pixels checked) over %0d register writes, layouts %b.",
             frames_seen, pixels_checked, cfg_writes, layouts_seen);
    $display("Clamped widths %0d..%0d, heights %0d..%0d, with sender gaps and output stalls.",
             min_w, max_w, min_h, max_h);
    if (err_cnt == 0 && rgb_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d pixels still expected", err_cnt, rgb_expected.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
